// File: rtl/core/time_of_day_calendar_counter_defines.svh
// assertion macros shared by the calendar counter rtl
// no dependencies; take in with `include inside a module body
`ifndef TIME_OF_DAY_CALENDAR_COUNTER_DEFINES_SVH
`define TIME_OF_DAY_CALENDAR_COUNTER_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define TDCC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tdcc check failed");

// next-cycle implication, checked while out of reset
`define TDCC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tdcc check failed");

`endif

// File: rtl/core/tdcc_pkg.sv
// constants and the month length table for the calendar counter
// no dependencies
package tdcc_pkg;

    localparam int unsigned TICKS_PER_SECOND_DEF = 32000;

    localparam int unsigned SUB_W   = 15;
    localparam int unsigned SEC_W   = 6;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned ADV_W   = 2;

    localparam logic [SEC_W-1:0]   SEC_LAST   = 6'd59;
    localparam logic [MIN_W-1:0]   MIN_LAST   = 6'd59;
    localparam logic [HOUR_W-1:0]  HOUR_LAST  = 5'd23;
    localparam logic [MONTH_W-1:0] MONTH_LAST = 4'd11;
    localparam logic [ADV_W-1:0]   ADV_SAT    = 2'd3;

    localparam logic [DAY_W-1:0] LAST_DAY_FEB   = 5'd27;
    localparam logic [DAY_W-1:0] LAST_DAY_LONG  = 5'd30;
    localparam logic [DAY_W-1:0] LAST_DAY_SHORT = 5'd29;

    localparam logic [MONTH_W-1:0] JAN = 4'd0;
    localparam logic [MONTH_W-1:0] FEB = 4'd1;
    localparam logic [MONTH_W-1:0] MAR = 4'd2;
    localparam logic [MONTH_W-1:0] MAY = 4'd4;
    localparam logic [MONTH_W-1:0] JUL = 4'd6;
    localparam logic [MONTH_W-1:0] AUG = 4'd7;
    localparam logic [MONTH_W-1:0] OCT = 4'd9;
    localparam logic [MONTH_W-1:0] DEC = 4'd11;

    // zero-based last day of a zero-based month, no leap year
    function automatic logic [DAY_W-1:0] last_day_of(input logic [MONTH_W-1:0] month);
        logic [DAY_W-1:0] d;
        case (month) inside
            FEB:                               d = LAST_DAY_FEB;
            JAN, MAR, MAY, JUL, AUG, OCT, DEC: d = LAST_DAY_LONG;
            default:                           d = LAST_DAY_SHORT;
        endcase
        return d;
    endfunction

endpackage

// File: rtl/core/time_of_day_calendar_counter.sv
// time-of-day and calendar counter, single module
// depends on tdcc_pkg and time_of_day_calendar_counter_defines.svh
//
// usage
//   s_ channel: one beat per elapsed interval, s_elapsed_ticks in 1/32 ms ticks
//   m_ channel: one beat per input beat, the full time and date after the
//     interval was applied, plus how many whole seconds it carried (saturates at 3)
//   path: a taken beat lands in a one-deep input register and is applied to
//     the result register once that register is free or being drained
//   throughput: one beat per cycle while m_ready is high; the carry of the
//     whole seconds in a beat through seconds, minutes, hours, day and month
//     is one pass of compare and select logic between the input register
//     and the result register; it also closes the loop on the counter state
//   stall: while the result waits, one more beat is taken into the input
//     register; after that s_ready drops until m_ready returns
//   reset: aresetn low at an edge clears the counters to 00:00:00, day 0,
//     month 0 and empties both registers; s_ready is not gated by reset and
//     drops only while the input register is full
//   the counters live in the result register, so the shown time is always the
//   state that the next beat builds on
module time_of_day_calendar_counter #(
    parameter int unsigned TICKS_PER_SECOND = tdcc_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [tdcc_pkg::SUB_W-1:0]       s_elapsed_ticks,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [tdcc_pkg::SUB_W-1:0]       m_subsecond_out,
    output logic [tdcc_pkg::SEC_W-1:0]       m_seconds_out,
    output logic [tdcc_pkg::MIN_W-1:0]       m_minutes_out,
    output logic [tdcc_pkg::HOUR_W-1:0]      m_hours_out,
    output logic [tdcc_pkg::DAY_W-1:0]       m_day_out,
    output logic [tdcc_pkg::MONTH_W-1:0]     m_month_out,
    output logic [tdcc_pkg::ADV_W-1:0]       m_seconds_advanced
);
    import tdcc_pkg::*;

    `include "time_of_day_calendar_counter_defines.svh"

    // sum of held ticks (< TICKS_PER_SECOND) and one beat
    localparam int unsigned SUM_W = SUB_W + 1;
    // most whole seconds a single beat can carry
    localparam int unsigned Q_MAX = 1 + ((1 << SUB_W) - 1) / TICKS_PER_SECOND;
    localparam int unsigned Q_W   = $clog2(Q_MAX + 1);
    // seconds plus carried seconds stays below twice a minute
    localparam int unsigned SSUM_W = SEC_W + 1;

    // input register
    logic             in_valid_reg;
    logic [SUB_W-1:0] ticks_reg;

    // result register, doubles as the counter state
    logic               out_valid_reg;
    logic [SUB_W-1:0]   sub_reg,   sub_next;
    logic [SEC_W-1:0]   sec_reg,   sec_next;
    logic [MIN_W-1:0]   min_reg,   min_next;
    logic [HOUR_W-1:0]  hour_reg,  hour_next;
    logic [DAY_W-1:0]   day_reg,   day_next;
    logic [MONTH_W-1:0] month_reg, month_next;
    logic [ADV_W-1:0]   adv_reg,   adv_next;

    logic              advance;
    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  base;
    logic [Q_W-1:0]    q;
    logic [SSUM_W-1:0] sec_sum;
    logic              sec_wrap, min_wrap, hour_wrap, month_end;

    // apply the held beat when the result register is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // whole seconds in the sum: compare against every multiple at once
    always_comb begin
        sum  = SUM_W'(sub_reg) + SUM_W'(ticks_reg);
        q    = '0;
        base = '0;
        for (int unsigned k = 1; k <= Q_MAX; k++) begin
            if (sum >= SUM_W'(k * TICKS_PER_SECOND)) begin
                q    = Q_W'(k);
                base = SUM_W'(k * TICKS_PER_SECOND);
            end
        end
    end

    // carry chain; at most one minute wraps per beat
    always_comb begin
        sub_next  = SUB_W'(sum - base);
        adv_next  = (q >= Q_W'(ADV_SAT)) ? ADV_SAT : ADV_W'(q);
        sec_sum   = SSUM_W'(sec_reg) + SSUM_W'(q);
        sec_wrap  = sec_sum > SSUM_W'(SEC_LAST);
        sec_next  = sec_wrap ? SEC_W'(sec_sum - SSUM_W'(SEC_LAST) - SSUM_W'(1))
                             : SEC_W'(sec_sum);
        min_wrap  = sec_wrap && (min_reg == MIN_LAST);
        hour_wrap = min_wrap && (hour_reg == HOUR_LAST);
        month_end = hour_wrap && (day_reg == last_day_of(month_reg));

        min_next   = min_reg;
        hour_next  = hour_reg;
        day_next   = day_reg;
        month_next = month_reg;
        if (sec_wrap) begin
            min_next = min_wrap ? '0 : min_reg + MIN_W'(1);
        end
        if (min_wrap) begin
            hour_next = hour_wrap ? '0 : hour_reg + HOUR_W'(1);
        end
        if (hour_wrap) begin
            day_next = month_end ? '0 : day_reg + DAY_W'(1);
        end
        if (month_end) begin
            month_next = (month_reg == MONTH_LAST) ? '0 : month_reg + MONTH_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sub_reg       <= '0;
            sec_reg       <= '0;
            min_reg       <= '0;
            hour_reg      <= '0;
            day_reg       <= '0;
            month_reg     <= '0;
            adv_reg       <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                sub_reg       <= sub_next;
                sec_reg       <= sec_next;
                min_reg       <= min_next;
                hour_reg      <= hour_next;
                day_reg       <= day_next;
                month_reg     <= month_next;
                adv_reg       <= adv_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload of the input register, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ticks_reg <= s_elapsed_ticks;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_subsecond_out    = sub_reg;
    assign m_seconds_out      = sec_reg;
    assign m_minutes_out      = min_reg;
    assign m_hours_out        = hour_reg;
    assign m_day_out          = day_reg;
    assign m_month_out        = month_reg;
    assign m_seconds_advanced = adv_reg;

    // counters stay in their ranges
    `TDCC_ASSERT_NOW(a_time_range, aclk, aresetn, 1'b1,
        (sec_reg <= SEC_LAST) && (min_reg <= MIN_LAST) && (hour_reg <= HOUR_LAST)
        && (month_reg <= MONTH_LAST) && (SUM_W'(sub_reg) < SUM_W'(TICKS_PER_SECOND)))
    `TDCC_ASSERT_NOW(a_day_range, aclk, aresetn, 1'b1, day_reg <= last_day_of(month_reg))
    // an applied beat always shows up as a result
    `TDCC_ASSERT_NEXT(a_advance_shows, aclk, aresetn, advance, out_valid_reg)
    // a beat with no whole second leaves the clock alone
    `TDCC_ASSERT_NEXT(a_no_carry_hold, aclk, aresetn, advance && (q == '0),
        (sec_reg == $past(sec_reg)) && (min_reg == $past(min_reg))
        && (adv_reg == '0))
    // a drained result with nothing behind it empties the result register
    `TDCC_ASSERT_NEXT(a_drain, aclk, aresetn, out_valid_reg && m_ready && !in_valid_reg,
        !out_valid_reg)

endmodule
